/* rtl/tlerc_pkg.sv */
// ----------------------------------------------------------------------------
// tlerc_pkg
// Shared types, key codes and defaults for the line edit reconstructor.
// ----------------------------------------------------------------------------
package tlerc_pkg;

  // Default sizes
  localparam int unsigned LINE_MAX_DEF  = 64;
  localparam int unsigned OP_DEPTH_DEF  = 4;
  localparam int unsigned RES_DEPTH_DEF = 4;

  // Control keys
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_ESC    = 8'h1b;
  localparam logic [7:0] KEY_TAB    = 8'h09;
  localparam logic [7:0] KEY_CTRL_C = 8'h03;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_LF     = 8'h0a;

  // Escape sequence characters
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_LEFT     = "D";
  localparam logic [7:0] CH_RIGHT    = "C";
  localparam logic [7:0] CH_UP       = "A";
  localparam logic [7:0] CH_DOWN     = "B";
  localparam logic [7:0] CH_HOME     = "1";
  localparam logic [7:0] CH_DELETE   = "3";
  localparam logic [7:0] CH_END      = "4";
  localparam logic [7:0] CH_PGUP     = "5";
  localparam logic [7:0] CH_PGDN     = "6";
  localparam logic [7:0] CH_TILDE    = "~";

  // Jump keywords, first character in the top byte
  localparam logic [31:0] PAT_FSSH    = "FSSH";
  localparam logic [55:0] PAT_FTELNET = "FTELNET";
  localparam int unsigned WIN_W       = 48;

  // Escape parser phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_BRACKET,
    PH_DIGIT
  } esc_phase_e;

  // Edit operations sent from the front end to the back end
  typedef enum logic [3:0] {
    OP_INSERT,
    OP_BACKSPACE,
    OP_DELETE,
    OP_LEFT,
    OP_RIGHT,
    OP_HOME,
    OP_END,
    OP_EMIT,
    OP_CLEAR
  } op_code_e;

  typedef struct packed {
    op_code_e   code;
    logic [7:0] data;
  } op_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT_UP,
    BK_SHIFT_DN,
    BK_PUT,
    BK_EMIT
  } bk_state_e;

  // One result item
  typedef struct packed {
    logic [7:0] line_char;
    logic       last_char;
    logic       line_empty;
    logic       jump_request;
  } res_t;

  // Keyword hit on the window of earlier characters plus the new one
  function automatic logic pat_hit(logic [WIN_W-1:0] win, logic [7:0] c);
    logic hit_ssh;
    logic hit_tel;
    hit_ssh = ({win[23:0], c} == PAT_FSSH);
    hit_tel = ({win[47:0], c} == PAT_FTELNET);
    return hit_ssh | hit_tel;
  endfunction

endpackage

/* rtl/tlerc_ram.sv */
// ----------------------------------------------------------------------------
// tlerc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlerc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tlerc_fifo.sv */
// ----------------------------------------------------------------------------
// tlerc_fifo
// Small flop based FIFO with occupancy count.
// ----------------------------------------------------------------------------
module tlerc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] ent_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = ent_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/tlerc_front.sv */
// ----------------------------------------------------------------------------
// tlerc_front
// Key classifier: tracks escape sequences and the raw byte count and turns
// each key into zero to three edit operations for the back end.
// ----------------------------------------------------------------------------
module tlerc_front
  import tlerc_pkg::*;
#(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF,
  localparam int unsigned AW      = $clog2(LINE_MAX)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] key_byte_i,
  output op_t        op_o,
  output logic       op_valid_o,
  input  logic       op_full_i
);

  esc_phase_e    phase_q, phase_d;
  logic [7:0]    held_q, held_d;
  logic [AW-1:0] raw_q, raw_d;
  op_t           pend_q [3];
  op_t           pend_d [3];
  logic [1:0]    pcnt_q, pcnt_d;

  logic       accept;
  logic       overflow;
  logic       is_eol;
  logic       is_ctrl_c;
  logic       is_esc;
  logic       is_lbr;
  logic       is_dir;
  logic       is_digit;
  logic       is_tilde;
  logic       idle_vld;
  op_code_e   idle_op;
  logic [1:0] fl_n;
  logic       m_vld;
  op_t        m_item;
  op_t        lst [3];
  logic [1:0] lst_n;
  logic       issue;

  // Key decode
  assign accept    = push & ~full;
  assign overflow  = (raw_q == AW'(LINE_MAX - 1));
  assign is_eol    = (key_byte_i == KEY_CR) || (key_byte_i == KEY_LF);
  assign is_ctrl_c = (key_byte_i == KEY_CTRL_C);
  assign is_esc    = (key_byte_i == KEY_ESC);
  assign is_lbr    = (key_byte_i == CH_LBRACKET);
  assign is_dir    = (key_byte_i == CH_LEFT) || (key_byte_i == CH_RIGHT) ||
                     (key_byte_i == CH_UP) || (key_byte_i == CH_DOWN);
  assign is_digit  = (key_byte_i == CH_HOME) || (key_byte_i == CH_DELETE) ||
                     (key_byte_i == CH_END) || (key_byte_i == CH_PGUP) ||
                     (key_byte_i == CH_PGDN);
  assign is_tilde  = (key_byte_i == CH_TILDE);

  // Plain key handling outside an escape
  assign idle_vld = (key_byte_i == KEY_DEL) || (!is_esc && (key_byte_i != KEY_TAB));
  assign idle_op  = (key_byte_i == KEY_DEL) ? OP_BACKSPACE : OP_INSERT;

  // Next state of the escape parser and byte counter
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    raw_d   = raw_q;
    if (accept) begin
      if (overflow || is_eol || is_ctrl_c) begin
        phase_d = PH_IDLE;
        held_d  = '0;
        raw_d   = '0;
      end else begin
        raw_d = raw_q + 1'b1;
        case (phase_q)
          PH_ESC: begin
            if (is_lbr) begin
              phase_d = PH_BRACKET;
            end else begin
              phase_d = is_esc ? PH_ESC : PH_IDLE;
            end
          end
          PH_BRACKET: begin
            if (is_dir) begin
              phase_d = PH_IDLE;
            end else if (is_digit) begin
              phase_d = PH_DIGIT;
              held_d  = key_byte_i;
            end else begin
              phase_d = is_esc ? PH_ESC : PH_IDLE;
              held_d  = '0;
            end
          end
          PH_DIGIT: begin
            held_d = '0;
            if (is_tilde) begin
              phase_d = PH_IDLE;
            end else begin
              phase_d = is_esc ? PH_ESC : PH_IDLE;
            end
          end
          default: begin
            phase_d = is_esc ? PH_ESC : PH_IDLE;
          end
        endcase
      end
    end
  end

  // Operations produced by the accepted key
  always_comb begin
    fl_n        = 2'd0;
    m_vld       = 1'b0;
    m_item.code = OP_INSERT;
    m_item.data = key_byte_i;
    if (overflow) begin
      m_vld       = 1'b1;
      m_item.code = OP_CLEAR;
    end else if (is_eol) begin
      m_vld       = 1'b1;
      m_item.code = OP_EMIT;
      if (phase_q == PH_BRACKET) begin
        fl_n = 2'd1;
      end else if (phase_q == PH_DIGIT) begin
        fl_n = 2'd2;
      end
    end else if (is_ctrl_c) begin
      m_vld       = 1'b1;
      m_item.code = OP_CLEAR;
    end else begin
      case (phase_q)
        PH_ESC: begin
          if (!is_lbr) begin
            m_vld       = idle_vld;
            m_item.code = idle_op;
          end
        end
        PH_BRACKET: begin
          if (key_byte_i == CH_LEFT) begin
            m_vld       = 1'b1;
            m_item.code = OP_LEFT;
          end else if (key_byte_i == CH_RIGHT) begin
            m_vld       = 1'b1;
            m_item.code = OP_RIGHT;
          end else if (!is_dir && !is_digit) begin
            fl_n        = 2'd1;
            m_vld       = idle_vld;
            m_item.code = idle_op;
          end
        end
        PH_DIGIT: begin
          if (is_tilde) begin
            if (held_q == CH_HOME) begin
              m_vld       = 1'b1;
              m_item.code = OP_HOME;
            end else if (held_q == CH_END) begin
              m_vld       = 1'b1;
              m_item.code = OP_END;
            end else if (held_q == CH_DELETE) begin
              m_vld       = 1'b1;
              m_item.code = OP_DELETE;
            end
          end else begin
            fl_n        = 2'd2;
            m_vld       = idle_vld;
            m_item.code = idle_op;
          end
        end
        default: begin
          m_vld       = idle_vld;
          m_item.code = idle_op;
        end
      endcase
    end
  end

  // Flushed escape characters go ahead of the key's own operation
  always_comb begin
    lst[0]      = m_item;
    lst[1]      = m_item;
    lst[2]      = m_item;
    if (fl_n != 2'd0) begin
      lst[0].code = OP_INSERT;
      lst[0].data = CH_LBRACKET;
    end
    if (fl_n == 2'd2) begin
      lst[1].code = OP_INSERT;
      lst[1].data = held_q;
    end
    lst_n = fl_n + {1'b0, m_vld};
  end

  // Pending operation buffer, drained one per cycle into the queue while the queue is not full
  assign op_o       = pend_q[0];
  assign op_valid_o = (pcnt_q != 2'd0);
  assign issue      = op_valid_o & ~op_full_i;
  assign full       = (pcnt_q != 2'd0);

  always_comb begin
    pend_d = pend_q;
    pcnt_d = pcnt_q;
    if (accept) begin
      pend_d = lst;
      pcnt_d = lst_n;
    end else if (issue) begin
      pend_d[0] = pend_q[1];
      pend_d[1] = pend_q[2];
      pcnt_d    = pcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      raw_q   <= '0;
      pcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      raw_q   <= raw_d;
      pcnt_q  <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

/* rtl/tlerc_back.sv */
// ----------------------------------------------------------------------------
// tlerc_back
// Edit engine: applies queued operations to the line store, shifting entries
// one per cycle, and streams the finished line into the result queue.
// ----------------------------------------------------------------------------
module tlerc_back
  import tlerc_pkg::*;
#(
  parameter int unsigned LINE_MAX  = LINE_MAX_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF,
  localparam int unsigned AW       = $clog2(LINE_MAX),
  localparam int unsigned CW       = $clog2(RES_DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  op_i,
  input  logic op_valid_i,
  output logic op_pop_o,
  output res_t res_o,
  output logic empty,
  input  logic pop
);

  bk_state_e        state_q, state_d;
  logic [AW-1:0]    len_q, len_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [AW-1:0]    rp_q, rp_d;
  logic [AW-1:0]    end_q, end_d;
  logic [7:0]       ch_q, ch_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic             rd_up_q, rd_up_d;
  logic             rd_emit_q, rd_emit_d;
  logic             rd_last_q, rd_last_d;
  logic [WIN_W-1:0] win_q, win_d;
  logic             found_q, found_d;

  logic          idle_go;
  logic          room;
  logic [CW:0]   occ;
  logic [CW-1:0] res_count;
  logic          res_full;
  logic          res_push;
  res_t          res_in;
  logic          hit_now;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  // Start a new operation only once the last shift write has landed
  assign idle_go = (state_q == BK_IDLE) && op_valid_i && !rd_vld_q;

  // Result queue space, counting a read still in flight
  assign occ  = {1'b0, res_count} + {{CW{1'b0}}, rd_vld_q};
  assign room = !res_full && (occ < (CW + 1)'(RES_DEPTH));

  assign hit_now = pat_hit(win_q, ram_rdata);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (idle_go) begin
          case (op_i.code)
            OP_INSERT: begin
              if (cur_q != len_q) state_d = BK_SHIFT_UP;
            end
            OP_BACKSPACE: begin
              if ((cur_q != '0) && (cur_q < len_q)) state_d = BK_SHIFT_DN;
            end
            OP_DELETE: begin
              if ((cur_q + 1'b1) < len_q) state_d = BK_SHIFT_DN;
            end
            OP_EMIT: begin
              state_d = BK_EMIT;
            end
            default: begin
              state_d = BK_IDLE;
            end
          endcase
        end
      end
      BK_SHIFT_UP: begin
        if (rp_q == cur_q) state_d = BK_PUT;
      end
      BK_SHIFT_DN: begin
        if (rp_q == end_q) state_d = BK_IDLE;
      end
      BK_PUT: begin
        if (!rd_vld_q) state_d = BK_IDLE;
      end
      BK_EMIT: begin
        if (room && ((len_q == '0) || (rp_q == end_q))) state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    len_d     = len_q;
    cur_d     = cur_q;
    rp_d      = rp_q;
    end_d     = end_q;
    ch_d      = ch_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rp_q;
    rd_up_d   = rd_up_q;
    rd_emit_d = 1'b0;
    rd_last_d = 1'b0;
    win_d     = win_q;
    found_d   = found_q;
    op_pop_o  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = rd_up_q ? rd_addr_q + 1'b1 : rd_addr_q - 1'b1;
    ram_wdata = ram_rdata;
    res_push  = 1'b0;
    res_in    = '{line_char: ram_rdata, last_char: rd_last_q, line_empty: 1'b0,
                  jump_request: rd_last_q & (found_q | hit_now)};

    // Returning read data: either a shifted entry or a line character
    if (rd_vld_q) begin
      if (rd_emit_q) begin
        res_push = 1'b1;
        win_d    = {win_q[WIN_W-9:0], ram_rdata};
        found_d  = found_q | hit_now;
      end else begin
        ram_we = 1'b1;
      end
    end

    case (state_q)
      BK_IDLE: begin
        if (idle_go) begin
          op_pop_o = 1'b1;
          case (op_i.code)
            OP_INSERT: begin
              ch_d = op_i.data;
              if (cur_q == len_q) begin
                ram_we    = 1'b1;
                ram_waddr = cur_q;
                ram_wdata = op_i.data;
                len_d     = len_q + 1'b1;
                cur_d     = cur_q + 1'b1;
              end else begin
                rp_d    = len_q - 1'b1;
                rd_up_d = 1'b1;
              end
            end
            OP_BACKSPACE: begin
              if (cur_q != '0) begin
                cur_d   = cur_q - 1'b1;
                len_d   = len_q - 1'b1;
                rp_d    = cur_q;
                end_d   = len_q - 1'b1;
                rd_up_d = 1'b0;
              end
            end
            OP_DELETE: begin
              if (cur_q < len_q) begin
                len_d   = len_q - 1'b1;
                rp_d    = cur_q + 1'b1;
                end_d   = len_q - 1'b1;
                rd_up_d = 1'b0;
              end
            end
            OP_LEFT: begin
              if (cur_q != '0) cur_d = cur_q - 1'b1;
            end
            OP_RIGHT: begin
              if (cur_q < len_q) cur_d = cur_q + 1'b1;
            end
            OP_HOME: begin
              cur_d = '0;
            end
            OP_END: begin
              cur_d = len_q;
            end
            OP_EMIT: begin
              rp_d    = '0;
              end_d   = len_q - 1'b1;
              win_d   = '0;
              found_d = 1'b0;
            end
            OP_CLEAR: begin
              len_d = '0;
              cur_d = '0;
            end
            default: begin
              len_d = len_q;
            end
          endcase
        end
      end
      BK_SHIFT_UP, BK_SHIFT_DN: begin
        ram_re    = 1'b1;
        rd_vld_d  = 1'b1;
        rd_addr_d = rp_q;
        rp_d      = rd_up_q ? rp_q - 1'b1 : rp_q + 1'b1;
      end
      BK_PUT: begin
        if (!rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q;
          ram_wdata = ch_q;
          len_d     = len_q + 1'b1;
          cur_d     = cur_q + 1'b1;
        end
      end
      BK_EMIT: begin
        if (room) begin
          if (len_q == '0) begin
            res_push = 1'b1;
            res_in   = '{line_char: 8'h00, last_char: 1'b1, line_empty: 1'b1,
                         jump_request: 1'b0};
          end else begin
            ram_re    = 1'b1;
            rd_vld_d  = 1'b1;
            rd_emit_d = 1'b1;
            rd_addr_d = rp_q;
            rd_last_d = (rp_q == end_q);
            rp_d      = rp_q + 1'b1;
          end
          if ((len_q == '0) || (rp_q == end_q)) begin
            len_d = '0;
            cur_d = '0;
          end
        end
      end
      default: begin
        rp_d = rp_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      len_q     <= '0;
      cur_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_emit_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      cur_q     <= cur_d;
      rd_vld_q  <= rd_vld_d;
      rd_emit_q <= rd_emit_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q      <= rp_d;
    end_q     <= end_d;
    ch_q      <= ch_d;
    rd_addr_q <= rd_addr_d;
    rd_up_q   <= rd_up_d;
    rd_last_q <= rd_last_d;
    win_q     <= win_d;
  end

  // Line store
  tlerc_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // Result queue
  logic [$bits(res_t)-1:0] res_vec;

  tlerc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_vec),
    .empty_o (empty),
    .full_o  (res_full),
    .count_o (res_count)
  );

  assign res_o = res_t'(res_vec);

endmodule

/* rtl/terminal_line_edit_reconstructor_core.sv */
// ----------------------------------------------------------------------------
// terminal_line_edit_reconstructor_core
// Rebuilds an edited command line from raw keystroke bytes.
//
// Keys are taken one at a time; the front end passes on every edit operation
// that a key produces (up to three, when a broken escape sequence is flushed
// as text) before it takes the next key. The back end applies the operations
// from a short queue: cursor moves and an insert at the line end move no other
// character, while an insert, backspace or delete inside the line moves the
// characters after the cursor one by one, since the line store has a single
// read and a single write port and entries move one per cycle. On CR or LF the
// line streams out one character per cycle while the result queue has room; an
// empty line gives one result. The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module terminal_line_edit_reconstructor_core
  import tlerc_pkg::*;
#(
  parameter int unsigned LINE_MAX  = LINE_MAX_DEF,
  parameter int unsigned OP_DEPTH  = OP_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] key_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] line_char_o,
  output logic       last_char_o,
  output logic       line_empty_o,
  output logic       jump_request_o
);

  localparam int unsigned OCW = $clog2(OP_DEPTH + 1);

  op_t                    fr_op;
  logic                   fr_op_valid;
  logic                   opq_full;
  logic                   opq_empty;
  logic [$bits(op_t)-1:0] opq_data;
  logic [OCW-1:0]         opq_count;
  logic                   bk_pop;
  res_t                   res;

  // Front end: key classification
  tlerc_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .key_byte_i (key_byte_i),
    .op_o       (fr_op),
    .op_valid_o (fr_op_valid),
    .op_full_i  (opq_full)
  );

  // Operation queue between the two halves
  tlerc_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OP_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_op_valid),
    .data_i  (fr_op),
    .pop_i   (bk_pop),
    .data_o  (opq_data),
    .empty_o (opq_empty),
    .full_o  (opq_full),
    .count_o (opq_count)
  );

  // Back end: line editing and output
  tlerc_back #(
    .LINE_MAX  (LINE_MAX),
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_t'(opq_data)),
    .op_valid_i (~opq_empty & (opq_count != '0)),
    .op_pop_o   (bk_pop),
    .res_o      (res),
    .empty      (empty),
    .pop        (pop)
  );

  assign line_char_o    = res.line_char;
  assign last_char_o    = res.last_char;
  assign line_empty_o   = res.line_empty;
  assign jump_request_o = res.jump_request;

endmodule
